// File: hw/rtl/pfr_pkg.sv
// ============================================================================
// Pareto front ranker package
// Word formats, field widths and sequencer states shared by the ranker files.
// ============================================================================
package pfr_pkg;

    localparam int FIELD_W  = 16;   // width of one objective field on the port
    localparam int MARGIN_W = 16;   // width of the dominance margin register
    localparam int RANK_W   = 7;    // width of a front number
    localparam int POS_W    = 6;    // width of a load-order position

    typedef struct packed {
        logic [FIELD_W-1:0] profit;
        logic [FIELD_W-1:0] activity;
        logic [FIELD_W-1:0] risk_score;
        logic               last_in_set;
    } t_in_word;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [RANK_W-1:0] front_no;
        logic              final_result;
        logic              dropped;
    } t_out_word;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PASS_START,
        S_I_FETCH,
        S_I_LATCH,
        S_J_SCAN,
        S_J_DONE,
        S_PASS_END,
        S_FILL,
        S_OUT_RD,
        S_OUT_CAP,
        S_OUT_WAIT
    } t_state;

endpackage

// File: hw/rtl/pfr_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ============================================================================
module pfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/pfr_dom_cmp.sv
// ============================================================================
// Pareto dominance compare
// Decide whether candidate A dominates candidate B under a margin.
// ============================================================================
module pfr_dom_cmp
    import pfr_pkg::*;
#(
    parameter int OBJ_W = 16
) (
    input  logic [3*OBJ_W-1:0]  i_obj_a,
    input  logic [3*OBJ_W-1:0]  i_obj_b,
    input  logic [MARGIN_W-1:0] i_margin,
    output logic                o_beats
);

    localparam int SUM_W = ((OBJ_W > MARGIN_W) ? OBJ_W : MARGIN_W) + 1;

    logic [2:0] worse;
    logic [2:0] better;

    // A is worse when A + eps < B, better when A > B + eps
    always_comb begin
        logic [SUM_W-1:0] a_ext;
        logic [SUM_W-1:0] b_ext;
        logic [SUM_W-1:0] m_ext;
        for (int k = 0; k < 3; k++) begin
            a_ext     = SUM_W'(i_obj_a[k*OBJ_W +: OBJ_W]);
            b_ext     = SUM_W'(i_obj_b[k*OBJ_W +: OBJ_W]);
            m_ext     = SUM_W'(i_margin);
            worse[k]  = (a_ext + m_ext) < b_ext;
            better[k] = a_ext > (b_ext + m_ext);
        end
    end

    assign o_beats = (worse == 3'b000) && (better != 3'b000);

endmodule

// File: hw/rtl/pareto_front_ranker.sv
// ============================================================================
// Pareto front ranker
// Load a set of candidates, sort them into Pareto fronts, emit ranks in order.
// ============================================================================
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+---------------------------
//  in      | sink      | i_in_valid / o_in_stall    | t_in_word: 3 objectives,
//          |           |                            |   last_in_set
//  out     | source    | o_out_valid / i_out_stall  | t_out_word: position, rank,
//          |           |                            |   final_result, dropped
//  cfg     | sink      | i_cfg_valid / o_cfg_ready  | dominance margin, 16 bit
//
// Loading takes one cycle per word. Ranking runs one pass over the set per
// front; for each unranked candidate the one read port of the objective RAM
// feeds one dominance compare per cycle. Each result is then read from the
// rank RAM, captured and held until it is taken past any output stall.
// Reset (synchronous, active low) clears the sequencer, counts and margin;
// the RAMs are not cleared. The input is stalled from the last word of a set
// until its final result has been taken.
// ============================================================================
module pareto_front_ranker
    import pfr_pkg::*;
#(
    parameter int MAX_CANDIDATES = 64,
    parameter int OBJ_WIDTH      = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // candidate words
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_word            i_in,
    // rank words
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_word           o_out,
    // margin register write
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [MARGIN_W-1:0] i_cfg_data
);

    localparam int IDX_W   = $clog2(MAX_CANDIDATES);
    localparam int CNT_W   = $clog2(MAX_CANDIDATES + 1);
    localparam int STORE_W = (OBJ_WIDTH < FIELD_W) ? OBJ_WIDTH : FIELD_W;
    localparam int WORD_W  = 3 * STORE_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CANDIDATES);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;        // candidates stored in set
    logic                  r_ovf, n_ovf;            // a word was dropped
    logic [MARGIN_W-1:0]   r_margin;
    logic [RANK_W-1:0]     r_front, n_front;        // front being built
    logic [CNT_W-1:0]      r_left, n_left;          // candidates still unranked
    logic [CNT_W-1:0]      r_found, n_found;        // members of this front
    logic [CNT_W-1:0]      r_i, n_i;                // candidate under test / sweep
    logic [CNT_W-1:0]      r_j, n_j;                // challenger read address
    logic [IDX_W-1:0]      r_jd, n_jd;              // challenger whose data is out
    logic                  r_jd_vld, n_jd_vld;
    logic                  r_hit, n_hit;            // candidate i is dominated
    logic [MAX_CANDIDATES-1:0] r_ranked, n_ranked;  // ranked in an earlier front
    logic [MAX_CANDIDATES-1:0] r_in_front, n_in_front;
    logic                  r_out_vld, n_out_vld;
    logic [WORD_W-1:0]     r_obj_i;                 // objectives of candidate i
    t_out_word             r_out;

    // ------------------------------------------------------------------------
    // RAM ports and compare unit
    // ------------------------------------------------------------------------
    logic                  obj_we, obj_re;
    logic [IDX_W-1:0]      obj_waddr, obj_raddr;
    logic [WORD_W-1:0]     obj_wdata, obj_rdata;
    logic                  rank_we, rank_re;
    logic [IDX_W-1:0]      rank_waddr, rank_raddr;
    logic [RANK_W-1:0]     rank_wdata, rank_rdata;
    logic                  dom_beats;
    logic                  beat_hit;
    logic [IDX_W-1:0]      i_idx;

    assign i_idx     = r_i[IDX_W-1:0];
    assign obj_wdata = {i_in.profit[STORE_W-1:0],
                        i_in.activity[STORE_W-1:0],
                        i_in.risk_score[STORE_W-1:0]};

    pfr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_CANDIDATES)
    ) u_obj_ram (
        .i_clk     (i_clk),
        .i_wr_en   (obj_we),
        .i_wr_addr (obj_waddr),
        .i_wr_data (obj_wdata),
        .i_rd_en   (obj_re),
        .i_rd_addr (obj_raddr),
        .o_rd_data (obj_rdata)
    );

    pfr_ram #(
        .WIDTH (RANK_W),
        .DEPTH (MAX_CANDIDATES)
    ) u_rank_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rank_we),
        .i_wr_addr (rank_waddr),
        .i_wr_data (rank_wdata),
        .i_rd_en   (rank_re),
        .i_rd_addr (rank_raddr),
        .o_rd_data (rank_rdata)
    );

    // challenger (RAM data) against the candidate held in r_obj_i
    pfr_dom_cmp #(
        .OBJ_W (STORE_W)
    ) u_dom_cmp (
        .i_obj_a  (obj_rdata),
        .i_obj_b  (r_obj_i),
        .i_margin (r_margin),
        .o_beats  (dom_beats)
    );

    // count a challenger only if it is another candidate that is still unranked
    assign beat_hit = r_jd_vld && (r_jd != i_idx) && !r_ranked[r_jd] && dom_beats;

    // ------------------------------------------------------------------------
    // Sequencer: next state, counters and RAM controls
    // ------------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_front    = r_front;
        n_left     = r_left;
        n_found    = r_found;
        n_i        = r_i;
        n_j        = r_j;
        n_jd       = r_jd;
        n_jd_vld   = r_jd_vld;
        n_hit      = r_hit;
        n_ranked   = r_ranked;
        n_in_front = r_in_front;
        n_out_vld  = r_out_vld;
        obj_we     = 1'b0;
        obj_waddr  = r_count[IDX_W-1:0];
        obj_re     = 1'b0;
        obj_raddr  = i_idx;
        rank_we    = 1'b0;
        rank_waddr = i_idx;
        rank_wdata = r_front;
        rank_re    = 1'b0;
        rank_raddr = i_idx;

        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    // store while room is left, otherwise drop and flag
                    if (r_count < CNT_MAX) begin
                        obj_we  = 1'b1;
                        n_count = r_count + CNT_ONE;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last_in_set) begin
                        n_front  = RANK_W'(1);
                        n_left   = n_count;
                        n_ranked = '0;
                        n_state  = S_PASS_START;
                    end
                end
            end
            S_PASS_START: begin
                n_i        = '0;
                n_found    = '0;
                n_in_front = '0;
                n_state    = S_I_FETCH;
            end
            S_I_FETCH: begin
                if (r_i == r_count) begin
                    n_state = S_PASS_END;
                end else if (r_ranked[i_idx]) begin
                    n_i = r_i + CNT_ONE;
                end else begin
                    obj_re  = 1'b1;
                    n_state = S_I_LATCH;
                end
            end
            S_I_LATCH: begin
                n_j      = '0;
                n_hit    = 1'b0;
                n_jd_vld = 1'b0;
                n_state  = S_J_SCAN;
            end
            S_J_SCAN: begin
                // issue challenger j while judging the one read last cycle
                n_hit = r_hit | beat_hit;
                if (r_j != r_count) begin
                    obj_re    = 1'b1;
                    obj_raddr = r_j[IDX_W-1:0];
                    n_jd      = r_j[IDX_W-1:0];
                    n_jd_vld  = 1'b1;
                    n_j       = r_j + CNT_ONE;
                end else begin
                    n_jd_vld = 1'b0;
                    n_state  = S_J_DONE;
                end
            end
            S_J_DONE: begin
                if (!r_hit) begin
                    n_in_front[i_idx] = 1'b1;
                    n_found           = r_found + CNT_ONE;
                    rank_we           = 1'b1;
                end
                n_i     = r_i + CNT_ONE;
                n_state = S_I_FETCH;
            end
            S_PASS_END: begin
                if (r_found == '0) begin
                    // no undominated candidate: the rest share this front
                    n_i     = '0;
                    n_state = S_FILL;
                end else begin
                    n_ranked = r_ranked | r_in_front;
                    n_left   = r_left - r_found;
                    if (r_left == r_found) begin
                        n_i     = '0;
                        n_state = S_OUT_RD;
                    end else begin
                        n_front = r_front + RANK_W'(1);
                        n_state = S_PASS_START;
                    end
                end
            end
            S_FILL: begin
                if (r_i == r_count) begin
                    n_i     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    rank_we = !r_ranked[i_idx];
                    n_i     = r_i + CNT_ONE;
                end
            end
            S_OUT_RD: begin
                rank_re = 1'b1;
                n_state = S_OUT_CAP;
            end
            S_OUT_CAP: begin
                n_out_vld = 1'b1;
                n_state   = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (!i_out_stall) begin
                    n_out_vld = 1'b0;
                    if ((r_i + CNT_ONE) == r_count) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_i     = r_i + CNT_ONE;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // State register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_margin   <= '0;
            r_front    <= '0;
            r_left     <= '0;
            r_found    <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_jd       <= '0;
            r_jd_vld   <= 1'b0;
            r_hit      <= 1'b0;
            r_ranked   <= '0;
            r_in_front <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_ovf      <= n_ovf;
            r_front    <= n_front;
            r_left     <= n_left;
            r_found    <= n_found;
            r_i        <= n_i;
            r_j        <= n_j;
            r_jd       <= n_jd;
            r_jd_vld   <= n_jd_vld;
            r_hit      <= n_hit;
            r_ranked   <= n_ranked;
            r_in_front <= n_in_front;
            r_out_vld  <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_margin <= i_cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_I_LATCH) begin
            r_obj_i <= obj_rdata;
        end
        if (r_state == S_OUT_CAP) begin
            r_out.position     <= POS_W'(r_i);
            r_out.front_no     <= rank_rdata;
            r_out.final_result <= (r_i + CNT_ONE) == r_count;
            r_out.dropped      <= r_ovf;
        end
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
    // the stored count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("stored candidate count above capacity");

    // a rank word is only shown for a stored candidate
    a_out_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == S_OUT_WAIT) && (r_i < r_count))
        else $error("rank word for a position outside the set");

    // a new pass only starts with candidates left to rank
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS_START) |-> (r_left != '0) && (r_left <= r_count))
        else $error("ranking pass started with nothing left");

    // taking the final word closes the set
    a_set_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out.final_result)
            |=> (r_count == '0) && !r_ovf && (r_state == S_LOAD))
        else $error("set state not cleared after final word");
`endif

endmodule
